// ===== design/rssm_pkg.sv =====
package rssm_pkg;

   // field widths
   localparam int SECTOR_W = 48;
   localparam int CHUNK_W  = 13;
   localparam int OFF_W    = 12;
   localparam int DISK_W   = 4;
   localparam int TOTAL_W  = 5;
   localparam int LEVEL_W  = 3;
   localparam int NPAR_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W    = 13;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 128;

   // effective register limits
   localparam logic [CHUNK_W-1:0] CHUNK_MAX   = CHUNK_W'(4096);
   localparam logic [DISK_W-1:0]  NDATA_MAX   = DISK_W'(14);
   localparam logic [NPAR_W-1:0]  NPAR_MAX    = NPAR_W'(2);

   // reset values
   localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(5);
   localparam logic [CHUNK_W-1:0] CHUNK_RST = CHUNK_W'(128);
   localparam logic [DISK_W-1:0]  NDATA_RST = DISK_W'(3);
   localparam logic [NPAR_W-1:0]  NPAR_RST  = NPAR_W'(1);

   // array levels that place parity
   localparam logic [LEVEL_W-1:0] LEVEL_FIXED_P  = LEVEL_W'(4);
   localparam logic [LEVEL_W-1:0] LEVEL_ROT_P    = LEVEL_W'(5);
   localparam logic [LEVEL_W-1:0] LEVEL_ROT_PQ   = LEVEL_W'(6);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CHUNK  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_NDATA  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_NPAR   = CSR_IDX_W'(3);

   // divider pipeline shape
   localparam int CHUNK_BITS_PER_STG = 4;
   localparam int CHUNK_STG = SECTOR_W / CHUNK_BITS_PER_STG;
   localparam int SMALL_BITS_PER_STG = 8;
   localparam int SLOT_STG  = SECTOR_W / SMALL_BITS_PER_STG;
   localparam int ROT_STG   = SECTOR_W / SMALL_BITS_PER_STG;
   localparam int MUL_STG   = 1;
   localparam int N_STG     = CHUNK_STG + SLOT_STG + ROT_STG + MUL_STG;

   typedef struct packed {
      logic                valid;
      logic [SECTOR_W-1:0] work;
      logic [OFF_W-1:0]    off;
      logic [DISK_W-1:0]   srem;
      logic [DISK_W-1:0]   slot;
      logic [SECTOR_W-1:0] stripe;
      logic [SECTOR_W-1:0] prod;
   } pipe_type;

   typedef struct packed {
      logic                valid;
      logic                q_valid;
      logic [DISK_W-1:0]   q_disk;
      logic                p_valid;
      logic [DISK_W-1:0]   p_disk;
      logic [OFF_W-1:0]    chunk_ofs;
      logic [SECTOR_W-1:0] stripe_index;
      logic [DISK_W-1:0]   member_disk;
      logic [SECTOR_W-1:0] physical_sector;
   } result_type;

   // one restoring step against the chunk size: {quotient bit, remainder}
   function automatic logic [OFF_W:0] chunk_step(input logic [OFF_W-1:0] rem,
                                                 input logic in_bit,
                                                 input logic [CHUNK_W-1:0] div);
      logic [CHUNK_W-1:0] t;
      logic [CHUNK_W-1:0] d;
      t = {rem, in_bit};
      d = t - div;
      if (t >= div) begin
         chunk_step = {1'b1, d[OFF_W-1:0]};
      end else begin
         chunk_step = {1'b0, t[OFF_W-1:0]};
      end
   endfunction

   // one restoring step against a disk count: {quotient bit, remainder}
   function automatic logic [DISK_W:0] small_step(input logic [DISK_W-1:0] rem,
                                                  input logic in_bit,
                                                  input logic [TOTAL_W-1:0] div);
      logic [TOTAL_W-1:0] t;
      logic [TOTAL_W-1:0] d;
      t = {rem, in_bit};
      d = t - div;
      if (t >= div) begin
         small_step = {1'b1, d[DISK_W-1:0]};
      end else begin
         small_step = {1'b0, t[DISK_W-1:0]};
      end
   endfunction

endpackage

// ===== design/raid_stripe_sector_mapper_unit.sv =====
// raid stripe sector mapper
//
// req channel: one beat per sector, req_tdata[47:0] = array lba.
// rsp channel: one beat per request, in request order, fields packed in
// rsp_tdata as listed beside the port.
// csr port: csr_we/csr_addr/csr_wdata write one register per cycle
// (0 level, 1 chunk size, 2 data disks, 3 parity disks); chunk size and
// disk counts are clamped as they are written, level is stored as written.
// write only while no beat is in flight.
//
// pipeline: 12 stages dividing by the chunk size at 4 bits a stage, 6
// stages dividing by the data disk count and 6 stages reducing the stripe
// by the total disk count at 8 bits a stage, one multiply stage, one
// output register.
// throughput: one beat per cycle unless stalled; dividers fully pipelined.
// stall: when rsp_tready is low with a result waiting, the whole pipe holds
// and req_tready drops; bubbles are not squeezed out, so the pipe holds as
// soon as the output register is full and not taken.
// reset: synchronous, clears all valid bits and loads the register defaults
// (level 5, 128-sector chunks, 3 data disks, 1 parity disk).
module raid_stripe_sector_mapper_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rssm_pkg::REQ_DATA_W-1:0]   req_tdata,   // lba
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // physical_sector[47:0], member_disk[51:48], stripe_index[99:52],
   // chunk_ofs[111:100], p_disk[115:112], p_valid[116], q_disk[120:117],
   // q_valid[121], zero[127:122]
   output logic [rssm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [rssm_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [rssm_pkg::CSR_W-1:0]        csr_wdata
);

   // configuration; chunk size and disk counts held as effective (clamped) values
   logic [rssm_pkg::LEVEL_W-1:0] level_ff;
   logic [rssm_pkg::CHUNK_W-1:0] chunk_ff;
   logic [rssm_pkg::DISK_W-1:0]  ndata_ff;
   logic [rssm_pkg::NPAR_W-1:0]  npar_ff;
   logic [rssm_pkg::TOTAL_W-1:0] total;

   logic [rssm_pkg::CHUNK_W-1:0] chunk_in;
   logic [rssm_pkg::DISK_W-1:0]  ndata_in;
   logic [rssm_pkg::NPAR_W-1:0]  npar_in;

   rssm_pkg::pipe_type stg_ff [rssm_pkg::N_STG];
   rssm_pkg::pipe_type stg_in [rssm_pkg::N_STG];
   rssm_pkg::pipe_type entry;
   rssm_pkg::result_type out_ff;
   rssm_pkg::result_type out_in;
   logic adv;

   assign total = rssm_pkg::TOTAL_W'(ndata_ff) + rssm_pkg::TOTAL_W'(npar_ff);

   // clamp on write
   always_comb begin
      chunk_in = csr_wdata;
      if (csr_wdata == '0) begin
         chunk_in = rssm_pkg::CHUNK_W'(1);
      end else if (csr_wdata > rssm_pkg::CHUNK_MAX) begin
         chunk_in = rssm_pkg::CHUNK_MAX;
      end
      ndata_in = csr_wdata[rssm_pkg::DISK_W-1:0];
      if (ndata_in == '0) begin
         ndata_in = rssm_pkg::DISK_W'(1);
      end else if (ndata_in > rssm_pkg::NDATA_MAX) begin
         ndata_in = rssm_pkg::NDATA_MAX;
      end
      npar_in = csr_wdata[rssm_pkg::NPAR_W-1:0];
      if (npar_in > rssm_pkg::NPAR_MAX) begin
         npar_in = rssm_pkg::NPAR_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= rssm_pkg::LEVEL_RST;
         chunk_ff <= rssm_pkg::CHUNK_RST;
         ndata_ff <= rssm_pkg::NDATA_RST;
         npar_ff  <= rssm_pkg::NPAR_RST;
      end else if (csr_we) begin
         case (csr_addr)
            rssm_pkg::REG_LEVEL: level_ff <= csr_wdata[rssm_pkg::LEVEL_W-1:0];
            rssm_pkg::REG_CHUNK: chunk_ff <= chunk_in;
            rssm_pkg::REG_NDATA: ndata_ff <= ndata_in;
            rssm_pkg::REG_NPAR:  npar_ff  <= npar_in;
            default: ;
         endcase
      end
   end

   // whole pipe moves unless a result is stuck at the output
   assign adv        = !out_ff.valid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      entry       = '0;
      entry.valid = req_tvalid;
      entry.work  = req_tdata;
   end

   for (genvar i = 0; i < rssm_pkg::N_STG; i++) begin : g_stg
      rssm_pkg::pipe_type prev;
      if (i == 0) begin : g_first
         assign prev = entry;
      end else begin : g_next
         assign prev = stg_ff[i-1];
      end

      if (i < rssm_pkg::CHUNK_STG) begin : g_chunk
         // sector / chunk size, quotient shifts into work
         always_comb begin
            logic [rssm_pkg::OFF_W:0] r;
            stg_in[i] = prev;
            for (int k = 0; k < rssm_pkg::CHUNK_BITS_PER_STG; k++) begin
               r = rssm_pkg::chunk_step(stg_in[i].off,
                                        stg_in[i].work[rssm_pkg::SECTOR_W-1], chunk_ff);
               stg_in[i].work = {stg_in[i].work[rssm_pkg::SECTOR_W-2:0],
                                 r[rssm_pkg::OFF_W]};
               stg_in[i].off  = r[rssm_pkg::OFF_W-1:0];
            end
         end
      end else if (i < rssm_pkg::CHUNK_STG + rssm_pkg::SLOT_STG) begin : g_slot
         // chunk number / data disks
         always_comb begin
            logic [rssm_pkg::DISK_W:0] r;
            stg_in[i] = prev;
            for (int k = 0; k < rssm_pkg::SMALL_BITS_PER_STG; k++) begin
               r = rssm_pkg::small_step(stg_in[i].srem,
                                        stg_in[i].work[rssm_pkg::SECTOR_W-1],
                                        rssm_pkg::TOTAL_W'(ndata_ff));
               stg_in[i].work = {stg_in[i].work[rssm_pkg::SECTOR_W-2:0],
                                 r[rssm_pkg::DISK_W]};
               stg_in[i].srem = r[rssm_pkg::DISK_W-1:0];
            end
         end
      end else if (i < rssm_pkg::N_STG - rssm_pkg::MUL_STG) begin : g_rot
         // stripe mod total disks; stripe and slot are latched on entry
         always_comb begin
            logic [rssm_pkg::DISK_W:0] r;
            stg_in[i] = prev;
            if (i == rssm_pkg::CHUNK_STG + rssm_pkg::SLOT_STG) begin
               stg_in[i].slot   = prev.srem;
               stg_in[i].stripe = prev.work;
               stg_in[i].srem   = '0;
            end
            for (int k = 0; k < rssm_pkg::SMALL_BITS_PER_STG; k++) begin
               r = rssm_pkg::small_step(stg_in[i].srem,
                                        stg_in[i].work[rssm_pkg::SECTOR_W-1], total);
               stg_in[i].work = {stg_in[i].work[rssm_pkg::SECTOR_W-2:0],
                                 r[rssm_pkg::DISK_W]};
               stg_in[i].srem = r[rssm_pkg::DISK_W-1:0];
            end
         end
      end else begin : g_mul
         // stripe * chunk size
         always_comb begin
            logic [rssm_pkg::SECTOR_W+rssm_pkg::CHUNK_W-1:0] full;
            full = {{rssm_pkg::CHUNK_W{1'b0}}, prev.stripe}
                 * {{rssm_pkg::SECTOR_W{1'b0}}, chunk_ff};
            stg_in[i]      = prev;
            stg_in[i].prod = full[rssm_pkg::SECTOR_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[i].valid <= 1'b0;
         end else if (adv) begin
            stg_ff[i].valid <= stg_in[i].valid;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[i].work   <= stg_in[i].work;
            stg_ff[i].off    <= stg_in[i].off;
            stg_ff[i].srem   <= stg_in[i].srem;
            stg_ff[i].slot   <= stg_in[i].slot;
            stg_ff[i].stripe <= stg_in[i].stripe;
            stg_ff[i].prod   <= stg_in[i].prod;
         end
      end
   end

   // parity placement and final sum
   always_comb begin
      rssm_pkg::pipe_type last;
      logic [rssm_pkg::TOTAL_W-1:0] rot5;
      logic [rssm_pkg::TOTAL_W-1:0] slot5;
      logic [rssm_pkg::TOTAL_W-1:0] s5;
      logic [rssm_pkg::TOTAL_W-1:0] p5;
      last  = stg_ff[rssm_pkg::N_STG-1];
      rot5  = rssm_pkg::TOTAL_W'(last.srem);
      slot5 = rssm_pkg::TOTAL_W'(last.slot);
      s5    = rot5 + rssm_pkg::TOTAL_W'(1) + slot5;
      p5    = total - rssm_pkg::TOTAL_W'(1) - rot5;

      out_in                 = '0;
      out_in.valid           = last.valid;
      out_in.physical_sector = last.prod + rssm_pkg::SECTOR_W'(last.off);
      out_in.stripe_index    = last.stripe;
      out_in.chunk_ofs       = last.off;
      out_in.member_disk     = last.slot;
      case (level_ff)
         rssm_pkg::LEVEL_FIXED_P: begin
            out_in.p_disk  = ndata_ff;
            out_in.p_valid = 1'b1;
         end
         rssm_pkg::LEVEL_ROT_P: begin
            out_in.p_disk  = last.srem;
            out_in.p_valid = 1'b1;
            if (s5 >= total) begin
               s5 = s5 - total;
            end
            out_in.member_disk = s5[rssm_pkg::DISK_W-1:0];
         end
         rssm_pkg::LEVEL_ROT_PQ: begin
            out_in.p_disk  = p5[rssm_pkg::DISK_W-1:0];
            out_in.p_valid = 1'b1;
            out_in.q_valid = 1'b1;
            if (last.srem == '0) begin
               // p on the last disk: q wraps to disk 0, data shifts up one
               out_in.q_disk      = '0;
               out_in.member_disk = last.slot + rssm_pkg::DISK_W'(1);
            end else begin
               out_in.q_disk = p5[rssm_pkg::DISK_W-1:0] + rssm_pkg::DISK_W'(1);
               if (slot5 >= p5) begin
                  out_in.member_disk = last.slot + rssm_pkg::DISK_W'(2);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff.valid <= out_in.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.q_valid         <= out_in.q_valid;
         out_ff.q_disk          <= out_in.q_disk;
         out_ff.p_valid         <= out_in.p_valid;
         out_ff.p_disk          <= out_in.p_disk;
         out_ff.chunk_ofs       <= out_in.chunk_ofs;
         out_ff.stripe_index    <= out_in.stripe_index;
         out_ff.member_disk     <= out_in.member_disk;
         out_ff.physical_sector <= out_in.physical_sector;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {6'b0, out_ff.q_valid, out_ff.q_disk, out_ff.p_valid, out_ff.p_disk,
                        out_ff.chunk_ofs, out_ff.stripe_index, out_ff.member_disk,
                        out_ff.physical_sector};

   // a q disk is never placed without a p disk
   a_q_needs_p: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.q_valid |-> out_ff.p_valid)
      else $error("q placed without p");

   // the chunk offset stays below the chunk size
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, out_ff.chunk_ofs} < chunk_ff))
      else $error("chunk offset out of range");

   // no request is taken while a result is stuck at the output
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request accepted during output stall");

endmodule
